// ===== hw/rtl/smid_pkg.sv =====
// Shared types, constants and bit-level helpers for the square marker id decoder.
package smid_pkg;

    localparam int GRID   = 7;
    localparam int PAY    = 5;
    localparam int ROTS   = 4;
    localparam int CELL_W = GRID * GRID;
    localparam int PAY_W  = PAY * PAY;
    localparam int ID_W   = 2 * PAY;

    typedef logic [PAY_W-1:0]  grid_t;
    typedef logic [CELL_W-1:0] cells_t;
    typedef logic [2:0]        row_dist_t;
    typedef logic [4:0]        total_t;
    typedef logic [1:0]        rot_t;
    typedef logic [ID_W-1:0]   marker_id_t;

    typedef enum logic [1:0] {
        ST_DECODED  = 2'd0,
        ST_BORDER   = 2'd1,
        ST_NO_MATCH = 2'd2
    } status_t;

    typedef struct packed {
        status_t    status;
        marker_id_t marker_id;
        rot_t       rotation;
        total_t     distance;
    } result_t;

    // bit x of a codeword is column x of a payload row
    localparam logic [PAY-1:0] CODEWORDS [ROTS] = '{5'h01, 5'h1D, 5'h12, 5'h0E};

    function automatic cells_t border_mask();
        cells_t m;
        m = '0;
        for (int r = 0; r < GRID; r++) begin
            for (int c = 0; c < GRID; c++) begin
                if (r == 0 || r == GRID - 1 || c == 0 || c == GRID - 1) begin
                    m[r*GRID+c] = 1'b1;
                end
            end
        end
        return m;
    endfunction

    function automatic grid_t extract_payload(cells_t cells);
        grid_t g;
        for (int r = 0; r < PAY; r++) begin
            for (int c = 0; c < PAY; c++) begin
                g[r*PAY+c] = cells[(r+1)*GRID+c+1];
            end
        end
        return g;
    endfunction

    // new(i, j) = old(PAY-1-j, i)
    function automatic grid_t quarter_turn(grid_t g);
        grid_t t;
        for (int i = 0; i < PAY; i++) begin
            for (int j = 0; j < PAY; j++) begin
                t[i*PAY+j] = g[(PAY-1-j)*PAY+i];
            end
        end
        return t;
    endfunction

    function automatic grid_t rotate_n(grid_t g, rot_t n);
        grid_t t;
        t = g;
        for (int i = 0; i < ROTS - 1; i++) begin
            if (i < int'(n)) begin
                t = quarter_turn(t);
            end
        end
        return t;
    endfunction

    // Hamming distance of one row to its nearest codeword
    function automatic row_dist_t row_distance(logic [PAY-1:0] row);
        row_dist_t best;
        row_dist_t d;
        logic [PAY-1:0] x;
        best = row_dist_t'(PAY);
        for (int p = 0; p < ROTS; p++) begin
            x = row ^ CODEWORDS[p];
            d = '0;
            for (int b = 0; b < PAY; b++) begin
                d = d + row_dist_t'(x[b]);
            end
            if (d < best) begin
                best = d;
            end
        end
        return best;
    endfunction

endpackage

// ===== hw/rtl/smid_cand_if.sv =====
// Candidate channel: one 7x7 grid of binarised cell bits per transfer.
interface smid_cand_if;
    logic                  valid;
    logic                  ready;
    logic [smid_pkg::CELL_W-1:0] cell_bits;

    modport source (output valid, output cell_bits, input ready);
    modport sink   (input valid, input cell_bits, output ready);
endinterface

// ===== hw/rtl/smid_res_if.sv =====
// Result channel: decode status, id, rotation and distance per transfer.
interface smid_res_if;
    logic                 valid;
    logic                 ready;
    smid_pkg::status_t    status;
    smid_pkg::marker_id_t marker_id;
    smid_pkg::rot_t       rotation;
    smid_pkg::total_t     distance;

    modport source (output valid, output status, output marker_id, output rotation,
                    output distance, input ready);
    modport sink   (input valid, input status, input marker_id, input rotation,
                    input distance, output ready);
endinterface

// ===== hw/rtl/square_marker_id_decode_unit.sv =====
// Top level of the square marker id decoder: four-stage valid/ready pipeline.
//
//  channel   dir   payload                                  per transfer
//  cand      in    cell_bits[48:0]                          one 7x7 candidate
//  result    out   status, marker_id, rotation, distance    one decode result
//
// Throughput: one candidate per cycle sustained while result is ready. The candidate
// transfer loads stage 1; the item then moves through stages 2, 3 and 4, and
// result.valid rises once it is in the stage 4 output register.
// Stage 1 checks the border and lifts the 5x5 payload; stage 2 scores every row
// of all four rotations; stage 3 sums the row scores; stage 4 picks the best
// rotation and packs the id into the output register.
// Reset clears the stage valid bits only; payload registers are not reset.
// A stall on result holds each full stage with no empty stage after it; ready ripples
// back stage by stage, so empty stages keep taking candidates while the output waits.
module square_marker_id_decode_unit (
    input  logic            clk,
    input  logic            rst_n,
    smid_cand_if.sink       cand,
    smid_res_if.source      result
);

    localparam smid_pkg::cells_t BORDER_MASK = smid_pkg::border_mask();

    // stage valids
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    // stage payloads
    smid_pkg::grid_t   pay1_reg, pay2_reg, pay3_reg;
    logic              bad1_reg, bad2_reg, bad3_reg;
    smid_pkg::row_dist_t [smid_pkg::ROTS-1:0][smid_pkg::PAY-1:0] dist2_reg;
    smid_pkg::total_t    [smid_pkg::ROTS-1:0]                    tot3_reg;
    smid_pkg::result_t res4_reg;

    // combinational next values
    smid_pkg::row_dist_t [smid_pkg::ROTS-1:0][smid_pkg::PAY-1:0] dist2_next;
    smid_pkg::total_t    [smid_pkg::ROTS-1:0]                    tot3_next;
    smid_pkg::result_t res4_next;

    // a stage moves when it is empty or the one after it moves
    assign adv4 = !v4_reg || result.ready;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    assign cand.ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= cand.valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // stage 2: row scores for each rotation
    for (genvar k = 0; k < smid_pkg::ROTS; k++)
    begin : g_rot
        smid_row_score #(
            .ROT (smid_pkg::rot_t'(k))
        ) u_score (
            .grid  (pay1_reg),
            .dists (dist2_next[k])
        );
    end

    // stage 3: per-rotation totals (at most 25, fits five bits)
    always_comb
    begin
        for (int k = 0; k < smid_pkg::ROTS; k++)
        begin
            tot3_next[k] = '0;
            for (int r = 0; r < smid_pkg::PAY; r++)
            begin
                tot3_next[k] = tot3_next[k] + smid_pkg::total_t'(dist2_reg[k][r]);
            end
        end
    end

    // stage 4: best rotation and id
    smid_pick u_pick (
        .totals     (tot3_reg),
        .grid       (pay3_reg),
        .border_bad (bad3_reg),
        .res        (res4_next)
    );

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            pay1_reg <= smid_pkg::extract_payload(cand.cell_bits);
            bad1_reg <= |(cand.cell_bits & BORDER_MASK);
        end
        if (adv2)
        begin
            dist2_reg <= dist2_next;
            pay2_reg  <= pay1_reg;
            bad2_reg  <= bad1_reg;
        end
        if (adv3)
        begin
            tot3_reg <= tot3_next;
            pay3_reg <= pay2_reg;
            bad3_reg <= bad2_reg;
        end
        if (adv4)
        begin
            res4_reg <= res4_next;
        end
    end

    assign result.valid     = v4_reg;
    assign result.status    = res4_reg.status;
    assign result.marker_id = res4_reg.marker_id;
    assign result.rotation  = res4_reg.rotation;
    assign result.distance  = res4_reg.distance;

    // border rejects carry nothing else
    a_border_clean: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && res4_reg.status == smid_pkg::ST_BORDER |->
            res4_reg.marker_id == '0 && res4_reg.rotation == '0 && res4_reg.distance == '0)
        else $error("border reject with non-zero fields");

    // a decoded id means an exact match
    a_decoded_exact: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && res4_reg.status == smid_pkg::ST_DECODED |-> res4_reg.distance == '0)
        else $error("decoded result with non-zero distance");

    // a fresh result must come from a full stage 3
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(v4_reg) |-> $past(v3_reg))
        else $error("result valid without a stage 3 item");

    // a held result must not be overwritten
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && !result.ready |=> v4_reg && $stable(res4_reg))
        else $error("stalled result changed");

    // distance never exceeds the payload size
    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> res4_reg.distance <= smid_pkg::total_t'(smid_pkg::PAY_W))
        else $error("distance out of range");

endmodule

// ===== hw/rtl/smid_row_score.sv =====
// Row scores of one rotation: nearest-codeword distance per payload row.
module smid_row_score #(
    parameter logic [1:0] ROT = 2'd0
) (
    input  smid_pkg::grid_t                        grid,
    output smid_pkg::row_dist_t [smid_pkg::PAY-1:0] dists
);

    smid_pkg::grid_t rot_grid;

    assign rot_grid = smid_pkg::rotate_n(grid, ROT);

    always_comb
    begin
        for (int r = 0; r < smid_pkg::PAY; r++)
        begin
            dists[r] = smid_pkg::row_distance(rot_grid[r*smid_pkg::PAY +: smid_pkg::PAY]);
        end
    end

endmodule

// ===== hw/rtl/smid_pick.sv =====
// Best-rotation select and id packing.
module smid_pick (
    input  smid_pkg::total_t [smid_pkg::ROTS-1:0] totals,
    input  smid_pkg::grid_t                       grid,
    input  logic                                  border_bad,
    output smid_pkg::result_t                     res
);

    smid_pkg::total_t     best_d;
    smid_pkg::rot_t       best_k;
    smid_pkg::grid_t      best_g;
    smid_pkg::marker_id_t id;

    always_comb
    begin
        best_d = totals[0];
        best_k = '0;
        // strict less-than keeps the earlier rotation on a tie
        for (int k = 1; k < smid_pkg::ROTS; k++)
        begin
            if (totals[k] < best_d)
            begin
                best_d = totals[k];
                best_k = smid_pkg::rot_t'(k);
            end
        end

        best_g = smid_pkg::rotate_n(grid, best_k);
        for (int r = 0; r < smid_pkg::PAY; r++)
        begin
            id[smid_pkg::ID_W-1-2*r] = best_g[r*smid_pkg::PAY+1];
            id[smid_pkg::ID_W-2-2*r] = best_g[r*smid_pkg::PAY+3];
        end

        if (border_bad)
        begin
            res.status    = smid_pkg::ST_BORDER;
            res.marker_id = '0;
            res.rotation  = '0;
            res.distance  = '0;
        end
        else if (best_d == '0)
        begin
            res.status    = smid_pkg::ST_DECODED;
            res.marker_id = id;
            res.rotation  = best_k;
            res.distance  = best_d;
        end
        else
        begin
            res.status    = smid_pkg::ST_NO_MATCH;
            res.marker_id = '0;
            res.rotation  = best_k;
            res.distance  = best_d;
        end
    end

endmodule
